FILE: design/pscb_pkg.sv
// Shared types, constants and codes for the polarity-split CSR edge table builder.
// No dependencies.
package pscb_pkg;

    localparam int VERTEX_DEPTH_DEF = 1024;
    localparam int EDGE_DEPTH_DEF   = 2048;
    localparam int SOURCE_SLOTS_DEF = 4;

    localparam int OP_W   = 3;
    localparam int VTX_W  = 10;
    localparam int QRY_W  = 11;
    localparam int POS_W  = 2;
    localparam int ST_W   = 2;
    localparam int SLOT_W = 11;
    localparam int CNT_W  = 12;
    localparam int VCFG_W = 11;
    localparam int ECFG_W = 12;
    localparam int CFG_W  = 12;

    localparam logic [OP_W-1:0] OP_COUNT    = 3'd0;
    localparam logic [OP_W-1:0] OP_FINALIZE = 3'd1;
    localparam logic [OP_W-1:0] OP_PLACE    = 3'd2;
    localparam logic [OP_W-1:0] OP_RD_EDGE  = 3'd3;
    localparam logic [OP_W-1:0] OP_RD_VTX   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_VTX  = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_SLOT = 2'd2;

    localparam logic CFG_VERTEX = 1'b0;
    localparam logic CFG_EDGE   = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the request and start the first memory reads
        logic check;    // evaluate the request with read data present
        logic commit;   // write back and load the result register
        logic clr_step; // one step of the post-reset clearing pass
        logic fin_step; // one step of the finalize walk
        logic fin_init; // start the finalize walk
    } pscb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic fin_done;
        logic fin_empty;
    } pscb_sts_t;

endpackage

FILE: design/polarity_split_csr_builder.sv
// Top level of the polarity-split CSR edge table builder: controller plus datapath.
// Depends on pscb_pkg, pscb_ctrl and pscb_dp.
// A request is captured when accepted, then checked and committed in the execute
// state, which loads the result register; a finalize with vertices in use first walks
// them, a read step then a write step per vertex, and commits after the walk. Requests
// are accepted only when idle, and a commit is held while an earlier result waits.
// Reset: synchronous, active low; after reset a clearing pass over all VERTEX_DEPTH
// vertex entries zeroes the counts and offsets, during which no request is accepted.
module polarity_split_csr_builder #(
    parameter int VERTEX_DEPTH = pscb_pkg::VERTEX_DEPTH_DEF,
    parameter int EDGE_DEPTH   = pscb_pkg::EDGE_DEPTH_DEF,
    parameter int SOURCE_SLOTS = pscb_pkg::SOURCE_SLOTS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [pscb_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [pscb_pkg::OP_W-1:0]    s_operation,
    input  logic [pscb_pkg::VTX_W-1:0]   s_source_vertex,
    input  logic [pscb_pkg::VTX_W-1:0]   s_target_vertex,
    input  logic                         s_negative,
    input  logic [pscb_pkg::QRY_W-1:0]   s_query_index,
    input  logic [pscb_pkg::POS_W-1:0]   s_source_position,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [pscb_pkg::ST_W-1:0]    m_status,
    output logic [pscb_pkg::SLOT_W-1:0]  m_edge_slot,
    output logic [pscb_pkg::VTX_W-1:0]   m_edge_target,
    output logic [pscb_pkg::CNT_W-1:0]   m_positive_base,
    output logic [pscb_pkg::CNT_W-1:0]   m_negative_base,
    output logic [pscb_pkg::CNT_W-1:0]   m_source_total,
    output logic [pscb_pkg::VTX_W-1:0]   m_source_entry
);
    import pscb_pkg::*;

    // The controller and the datapath exchange only command and status structs.
    pscb_cmd_t cmd;
    pscb_sts_t sts;

    pscb_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_operation,
        .m_valid, .m_ready, .cmd, .sts
    );

    pscb_dp #(
        .VERTEX_DEPTH(VERTEX_DEPTH), .EDGE_DEPTH(EDGE_DEPTH), .SOURCE_SLOTS(SOURCE_SLOTS)
    ) u_dp (
        .aclk, .aresetn, .cmd, .sts, .cfg_we, .cfg_index, .cfg_data,
        .s_operation, .s_source_vertex, .s_target_vertex, .s_negative,
        .s_query_index, .s_source_position,
        .m_status, .m_edge_slot, .m_edge_target, .m_positive_base,
        .m_negative_base, .m_source_total, .m_source_entry
    );

    // A result is produced only by a commit, and a commit never overwrites a
    // result that is still waiting.
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid || m_ready)) else $error("result overwritten");

    // A request is never accepted in the same cycle as a commit.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !cmd.commit) else $error("request during commit");

    // An error result carries no slot.
    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_edge_slot == '0)) else $error("dirty error");

endmodule

FILE: design/pscb_ctrl.sv
// Controller state machine of the CSR builder: sequences clearing, requests
// and the finalize walk. Depends on pscb_pkg.
module pscb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [pscb_pkg::OP_W-1:0] s_operation,
    output logic                m_valid,
    input  logic                m_ready,
    output pscb_pkg::pscb_cmd_t cmd,
    input  pscb_pkg::pscb_sts_t sts
);
    import pscb_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_FIN2  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;
    logic       is_fin_reg, is_fin_next;

    // A new request may enter while the result waits; its commit is held until
    // the result register is free again.
    wire out_free = !mvalid_reg || m_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg && !m_ready;
        is_fin_next = is_fin_reg;
        cmd = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    is_fin_next = (s_operation == OP_FINALIZE);
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.check = 1'b1;
                if (is_fin_reg && !sts.fin_empty) begin
                    cmd.fin_init = 1'b1;
                    state_next   = S_FIN;
                end else if (out_free) begin
                    cmd.commit  = 1'b1;
                    mvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_FIN: begin
                cmd.fin_step = 1'b1;
                if (sts.fin_done) state_next = S_FIN2;
            end
            S_FIN2: begin
                if (out_free) begin
                    cmd.commit  = 1'b1;
                    mvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            mvalid_reg <= 1'b0;
            is_fin_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            is_fin_reg <= is_fin_next;
        end
    end

endmodule

FILE: design/pscb_dp.sv
// Datapath of the CSR builder: vertex and edge memories, checks, the
// finalize prefix sum and the result register. Depends on pscb_pkg.
module pscb_dp #(
    parameter int VERTEX_DEPTH = pscb_pkg::VERTEX_DEPTH_DEF,
    parameter int EDGE_DEPTH   = pscb_pkg::EDGE_DEPTH_DEF,
    parameter int SOURCE_SLOTS = pscb_pkg::SOURCE_SLOTS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pscb_pkg::pscb_cmd_t          cmd,
    output pscb_pkg::pscb_sts_t          sts,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [pscb_pkg::CFG_W-1:0]   cfg_data,
    input  logic [pscb_pkg::OP_W-1:0]    s_operation,
    input  logic [pscb_pkg::VTX_W-1:0]   s_source_vertex,
    input  logic [pscb_pkg::VTX_W-1:0]   s_target_vertex,
    input  logic                         s_negative,
    input  logic [pscb_pkg::QRY_W-1:0]   s_query_index,
    input  logic [pscb_pkg::POS_W-1:0]   s_source_position,
    output logic [pscb_pkg::ST_W-1:0]    m_status,
    output logic [pscb_pkg::SLOT_W-1:0]  m_edge_slot,
    output logic [pscb_pkg::VTX_W-1:0]   m_edge_target,
    output logic [pscb_pkg::CNT_W-1:0]   m_positive_base,
    output logic [pscb_pkg::CNT_W-1:0]   m_negative_base,
    output logic [pscb_pkg::CNT_W-1:0]   m_source_total,
    output logic [pscb_pkg::VTX_W-1:0]   m_source_entry
);
    import pscb_pkg::*;

    localparam int VA_W  = $clog2(VERTEX_DEPTH);
    localparam int EA_W  = $clog2(EDGE_DEPTH);
    localparam int SA_W  = $clog2(VERTEX_DEPTH * SOURCE_SLOTS);
    localparam int VL_W  = $clog2(VERTEX_DEPTH + 1);
    localparam int EL_W  = $clog2(EDGE_DEPTH + 1);
    localparam int CMP_W = 18;

    // Fill counts and offsets for one vertex in one word.
    typedef struct packed {
        logic [CNT_W-1:0] pfill;
        logic [CNT_W-1:0] nfill;
        logic [CNT_W-1:0] poff;
        logic [CNT_W-1:0] noff;
    } vrec_t;

    vrec_t            vtx_mem [VERTEX_DEPTH];
    logic [CNT_W-1:0] inc_mem [VERTEX_DEPTH];
    logic [VTX_W-1:0] src_mem [VERTEX_DEPTH * SOURCE_SLOTS];
    logic [VTX_W-1:0] edge_mem [EDGE_DEPTH];

    logic [VCFG_W-1:0] vcnt_reg;
    logic [ECFG_W-1:0] ecnt_reg;

    logic [OP_W-1:0]  op_reg;
    logic [VTX_W-1:0] src_reg, tgt_reg;
    logic             neg_reg;
    logic [QRY_W-1:0] q_reg;
    logic [POS_W-1:0] pos_reg;

    vrec_t            vrd_reg;
    logic [CNT_W-1:0] inc_rd_reg;
    logic [VTX_W-1:0] srcrd_reg;
    logic [VTX_W-1:0] edrd_reg;

    logic [VA_W:0]    walk_reg;
    logic [CNT_W-1:0] run_reg;
    logic             rd_valid_reg;

    logic [ST_W-1:0]   st_reg;
    logic [SLOT_W-1:0] slot_o_reg;
    logic [VTX_W-1:0]  etgt_o_reg, sent_o_reg;
    logic [CNT_W-1:0]  pb_o_reg, nb_o_reg, tot_o_reg;

    // Effective limits.
    wire [VL_W-1:0] nv = (32'(vcnt_reg) < VERTEX_DEPTH) ? VL_W'(vcnt_reg) : VL_W'(VERTEX_DEPTH);
    wire [EL_W-1:0] ne = (32'(ecnt_reg) < EDGE_DEPTH) ? EL_W'(ecnt_reg) : EL_W'(EDGE_DEPTH);

    // Read address selection: at capture the incoming request, during the
    // walk and clearing the walk index.
    logic [VA_W-1:0] vaddr;
    always_comb begin
        priority if (cmd.capture) begin
            priority if (s_operation == OP_RD_VTX) vaddr = VA_W'(s_query_index);
            else if (s_operation == OP_PLACE || s_operation == OP_COUNT)
                vaddr = VA_W'(s_source_vertex);
            else vaddr = '0;
        end else begin
            vaddr = walk_reg[VA_W-1:0];
        end
    end

    wire [VA_W-1:0] iaddr = (s_operation == OP_RD_VTX) ? VA_W'(s_query_index)
                                                        : VA_W'(s_target_vertex);
    wire [SA_W-1:0] saddr = SA_W'(32'(VA_W'(s_query_index)) * SOURCE_SLOTS
                                  + 32'(s_source_position));

    // Place slot and checks, valid in the check cycle.
    wire [CNT_W:0] slot_sum = neg_reg ? ({1'b0, vrd_reg.noff} + {1'b0, vrd_reg.nfill})
                                      : ({1'b0, vrd_reg.poff} + {1'b0, vrd_reg.pfill});
    wire slot_ok  = CMP_W'(slot_sum) < CMP_W'(ne);
    wire q_e_ok   = CMP_W'(q_reg) < CMP_W'(ne);
    wire vtx_ok_r = CMP_W'(src_reg) < CMP_W'(nv) && CMP_W'(tgt_reg) < CMP_W'(nv);
    wire qv_ok_r  = CMP_W'(q_reg) < CMP_W'(nv);
    wire srcv_ok_r = CMP_W'(src_reg) < CMP_W'(nv);

    // Walk: the word of the current vertex arrives in the cycle after its address.
    wire [CNT_W-1:0] w_noff = run_reg + vrd_reg.pfill;
    wire [CNT_W-1:0] w_next = w_noff + vrd_reg.nfill;
    wire [VA_W:0]    wlast  = (VA_W+1)'(nv) - (VA_W+1)'(1);

    assign sts.clr_done  = (walk_reg == (VA_W+1)'(VERTEX_DEPTH - 1));
    assign sts.fin_done  = rd_valid_reg && (walk_reg == wlast);
    assign sts.fin_empty = (nv == '0);

    // Write port of the vertex word memory.
    logic            vwe;
    logic [VA_W-1:0] vwa;
    vrec_t           vwd;
    always_comb begin
        vwe = 1'b0;
        vwa = walk_reg[VA_W-1:0];
        vwd = vrd_reg;
        priority if (cmd.clr_step) begin
            vwe = 1'b1;
            vwd = '0;
        end else if (cmd.fin_step && rd_valid_reg) begin
            vwe = 1'b1;
            vwd.pfill = '0;
            vwd.nfill = '0;
            vwd.poff  = run_reg;
            vwd.noff  = w_noff;
        end else if (cmd.commit && op_reg == OP_COUNT && srcv_ok_r) begin
            vwe = 1'b1;
            vwa = VA_W'(src_reg);
            if (neg_reg) vwd.nfill = vrd_reg.nfill + CNT_W'(1);
            else         vwd.pfill = vrd_reg.pfill + CNT_W'(1);
        end else if (cmd.commit && op_reg == OP_PLACE && vtx_ok_r && slot_ok) begin
            vwe = 1'b1;
            vwa = VA_W'(src_reg);
            if (neg_reg) vwd.nfill = vrd_reg.nfill + CNT_W'(1);
            else         vwd.pfill = vrd_reg.pfill + CNT_W'(1);
        end
    end

    wire place_wr = cmd.commit && op_reg == OP_PLACE && vtx_ok_r && slot_ok;

    always_ff @(posedge aclk) begin
        if (cmd.capture || cmd.fin_step || cmd.fin_init) vrd_reg <= vtx_mem[vaddr];
        if (vwe) vtx_mem[vwa] <= vwd;
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) inc_rd_reg <= inc_mem[iaddr];
        if (cmd.clr_step) inc_mem[walk_reg[VA_W-1:0]] <= '0;
        else if (place_wr && inc_rd_reg != {CNT_W{1'b1}})
            inc_mem[VA_W'(tgt_reg)] <= inc_rd_reg + CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) srcrd_reg <= src_mem[saddr];
        if (place_wr && 32'(inc_rd_reg) < SOURCE_SLOTS)
            src_mem[SA_W'(32'(VA_W'(tgt_reg)) * SOURCE_SLOTS + 32'(inc_rd_reg))] <= src_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) edrd_reg <= edge_mem[EA_W'(s_query_index)];
        if (place_wr) edge_mem[EA_W'(slot_sum)] <= tgt_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= s_operation;
            src_reg <= s_source_vertex;
            tgt_reg <= s_target_vertex;
            neg_reg <= s_negative;
            q_reg   <= s_query_index;
            pos_reg <= s_source_position;
        end
    end

    // Walk index, running sum and config registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_reg     <= '0;
            run_reg      <= '0;
            rd_valid_reg <= 1'b0;
            vcnt_reg     <= VCFG_W'(1024);
            ecnt_reg     <= ECFG_W'(2048);
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_VERTEX) vcnt_reg <= cfg_data[VCFG_W-1:0];
                else                         ecnt_reg <= cfg_data[ECFG_W-1:0];
            end
            if (cmd.clr_step) begin
                walk_reg <= sts.clr_done ? '0 : walk_reg + (VA_W+1)'(1);
            end else if (cmd.fin_init) begin
                walk_reg     <= '0;
                run_reg      <= '0;
                rd_valid_reg <= 1'b1;
            end else if (cmd.fin_step) begin
                if (sts.fin_done) begin
                    walk_reg     <= '0;
                    rd_valid_reg <= 1'b0;
                end else begin
                    // Address and write share walk_reg, so each vertex gets
                    // a read step followed by a write step.
                    rd_valid_reg <= !rd_valid_reg;
                    if (rd_valid_reg) begin
                        run_reg  <= w_next;
                        walk_reg <= walk_reg + (VA_W+1)'(1);
                    end
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            st_reg     <= ST_OK;
            slot_o_reg <= '0;
            etgt_o_reg <= '0;
            pb_o_reg   <= '0;
            nb_o_reg   <= '0;
            tot_o_reg  <= '0;
            sent_o_reg <= '0;
            unique case (op_reg)
                OP_COUNT: if (!srcv_ok_r) st_reg <= ST_BAD_VTX;
                OP_PLACE: begin
                    if (!vtx_ok_r)     st_reg <= ST_BAD_VTX;
                    else if (!slot_ok) st_reg <= ST_BAD_SLOT;
                    else               slot_o_reg <= SLOT_W'(slot_sum);
                end
                OP_RD_EDGE: begin
                    if (!q_e_ok) st_reg <= ST_BAD_SLOT;
                    else         etgt_o_reg <= edrd_reg;
                end
                OP_RD_VTX: begin
                    if (!qv_ok_r) st_reg <= ST_BAD_VTX;
                    else begin
                        pb_o_reg  <= vrd_reg.poff;
                        nb_o_reg  <= vrd_reg.noff;
                        tot_o_reg <= inc_rd_reg;
                        if (32'(pos_reg) < SOURCE_SLOTS && CNT_W'(pos_reg) < inc_rd_reg)
                            sent_o_reg <= srcrd_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_status        = st_reg;
    assign m_edge_slot     = slot_o_reg;
    assign m_edge_target   = etgt_o_reg;
    assign m_positive_base = pb_o_reg;
    assign m_negative_base = nb_o_reg;
    assign m_source_total  = tot_o_reg;
    assign m_source_entry  = sent_o_reg;

endmodule
